// ===== hw/rtl/bes_pkg.sv =====
package bes_pkg;

    // Operation codes carried in the cmd field.
    localparam logic [2:0] CMD_CLASSIFY = 3'd0;
    localparam logic [2:0] CMD_SIGNBIT  = 3'd1;
    localparam logic [2:0] CMD_FREXP    = 3'd2;
    localparam logic [2:0] CMD_FABS     = 3'd3;
    localparam logic [2:0] CMD_COPYSIGN = 3'd4;
    localparam logic [2:0] CMD_SCALBN   = 3'd5;

    // Class codes returned by classify.
    localparam logic signed [15:0] CLS_NAN       = 16'sd0;
    localparam logic signed [15:0] CLS_INF       = 16'sd1;
    localparam logic signed [15:0] CLS_ZERO      = 16'sd2;
    localparam logic signed [15:0] CLS_SUBNORMAL = 16'sd3;
    localparam logic signed [15:0] CLS_NORMAL    = 16'sd4;

    // binary128 field constants.
    localparam logic [14:0] EXP_MAX  = 15'h7fff;
    localparam logic [14:0] HALF_EXP = 15'h3ffe;
    localparam int          FRAC_W   = 112;

    // Scaling stage limits.
    localparam logic signed [15:0] K_UP   = 16'sd16383;
    localparam logic signed [15:0] K_DOWN = -16'sd16269;
    localparam logic signed [15:0] K_MIN  = -16'sd16382;

    // Input beat.
    typedef struct packed {
        logic [2:0]         cmd;
        logic [63:0]        x_hi;
        logic [63:0]        x_lo;
        logic               y_sign;
        logic signed [31:0] scale;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic [63:0]        res_hi;
        logic [63:0]        res_lo;
        logic signed [15:0] res_int;
    } t_res;

    // Index of the highest set bit of a non-zero fraction.
    function automatic logic [6:0] f_top_bit(input logic [FRAC_W-1:0] f);
        logic [6:0] idx;
        idx = '0;
        for (int i = 0; i < FRAC_W; i++) begin
            if (f[i]) begin
                idx = 7'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/binary128_exponent_sign_unit_core.sv =====
// binary128 exponent and sign unit. One command beat may be issued on every
// clock cycle: busy is always low, and each result appears on o_res with
// o_done high for exactly one cycle, after passing through the pipeline
// registers below. The receiver cannot stall the unit, so results must
// be captured when o_done is high. The pipeline holds the input register,
// which also holds the split scale counts, one register after each of the
// first two power-of-two scaling stages, and the result register after the
// third stage.
module binary128_exponent_sign_unit_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bes_pkg::t_in  i_item,
    output logic          o_done,
    output bes_pkg::t_res o_res
);

    logic signed [33:0] n;
    logic signed [33:0] n1;
    logic signed [33:0] n2;
    logic signed [15:0] n_k1;
    logic signed [15:0] n_k2;
    logic signed [15:0] n_k3;

    logic               r_v0, r_v1, r_v2;
    logic [2:0]         r_cmd0, r_cmd1, r_cmd2;
    logic [127:0]       r_x0, r_x1, r_x2;
    logic               r_ys0, r_ys1, r_ys2;
    logic [127:0]       r_s1, r_s2;
    logic signed [15:0] r_k1, r_k2_0, r_k2_1, r_k3_0, r_k3_1, r_k3_2;

    logic [127:0]       s1_y, s2_y, s3_y;
    bes_pkg::t_res      n_res;

    assign busy = 1'b0;

    // Split the scale count into up to three clamped stage counts.
    always_comb begin
        n    = {{2{i_item.scale[31]}}, i_item.scale};
        n1   = n;
        n2   = n;
        n_k1 = '0;
        n_k2 = '0;
        n_k3 = n[15:0];
        if (n > 34'sd16383) begin
            n_k1 = bes_pkg::K_UP;
            n1   = n - 34'sd16383;
            n_k3 = n1[15:0];
            if (n1 > 34'sd16383) begin
                n_k2 = bes_pkg::K_UP;
                n2   = n1 - 34'sd16383;
                n_k3 = (n2 > 34'sd16383) ? bes_pkg::K_UP : n2[15:0];
            end
        end else if (n < -34'sd16382) begin
            n_k1 = bes_pkg::K_DOWN;
            n1   = n + 34'sd16269;
            n_k3 = n1[15:0];
            if (n1 < -34'sd16382) begin
                n_k2 = bes_pkg::K_DOWN;
                n2   = n1 + 34'sd16269;
                n_k3 = (n2 < -34'sd16382) ? bes_pkg::K_MIN : n2[15:0];
            end
        end
    end

    bes_scale u_scale1 (.i_x(r_x0), .i_k(r_k1),   .o_y(s1_y));
    bes_scale u_scale2 (.i_x(r_s1), .i_k(r_k2_1), .o_y(s2_y));
    bes_scale u_scale3 (.i_x(r_s2), .i_k(r_k3_2), .o_y(s3_y));

    bes_misc u_misc (
        .i_cmd   (r_cmd2),
        .i_x     (r_x2),
        .i_y_sign(r_ys2),
        .i_scaled(s3_y),
        .o_res   (n_res)
    );

    // Beat valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v0   <= start & ~busy;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            o_done <= r_v2;
        end
    end

    // Payload pipeline.
    always_ff @(posedge i_clk) begin
        r_cmd0 <= i_item.cmd;
        r_x0   <= {i_item.x_hi, i_item.x_lo};
        r_ys0  <= i_item.y_sign;
        r_k1   <= n_k1;
        r_k2_0 <= n_k2;
        r_k3_0 <= n_k3;

        r_cmd1 <= r_cmd0;
        r_x1   <= r_x0;
        r_ys1  <= r_ys0;
        r_s1   <= s1_y;
        r_k2_1 <= r_k2_0;
        r_k3_1 <= r_k3_0;

        r_cmd2 <= r_cmd1;
        r_x2   <= r_x1;
        r_ys2  <= r_ys1;
        r_s2   <= s2_y;
        r_k3_2 <= r_k3_1;

        o_res  <= n_res;
    end

endmodule

// ===== hw/rtl/bes_scale.sv =====
// One multiply by a power of two, k in [-16382, 16383], rounded to nearest even.
module bes_scale (
    input  logic [127:0]       i_x,
    input  logic signed [15:0] i_k,
    output logic [127:0]       o_y
);

    logic               sgn;
    logic [14:0]        ef;
    logic [111:0]       fr;
    logic [6:0]         p;
    logic [112:0]       mn;
    logic signed [17:0] b;
    logic signed [17:0] s;
    logic [225:0]       w;
    logic [112:0]       q;
    logic               guard;
    logic               sticky;
    logic               inc;

    always_comb begin
        sgn = i_x[127];
        ef  = i_x[126:112];
        fr  = i_x[111:0];
        p   = bes_pkg::f_top_bit(fr);

        // Normalise the significand and form the new biased exponent.
        if (ef != 15'd0) begin
            mn = {1'b1, fr};
            b  = $signed({3'b000, ef}) + $signed({{2{i_k[15]}}, i_k});
        end else begin
            mn = {1'b0, fr} << (7'd112 - p);
            b  = $signed({11'd0, p}) - 18'sd111 + $signed({{2{i_k[15]}}, i_k});
        end

        // Subnormal result: shift right by 1 - b and round.
        s      = 18'sd1 - b;
        w      = {mn, 113'd0} >> s[6:0];
        q      = w[225:113];
        guard  = w[112];
        sticky = |w[111:0];
        inc    = guard & (sticky | q[0]);

        if (ef == bes_pkg::EXP_MAX) begin
            o_y = i_x;
            if (fr != '0) begin
                o_y[111] = 1'b1;
            end
        end else if (ef == 15'd0 && fr == '0) begin
            o_y = i_x;
        end else if (b >= 18'sd32767) begin
            o_y = {sgn, bes_pkg::EXP_MAX, 112'd0};
        end else if (b >= 18'sd1) begin
            o_y = {sgn, b[14:0], mn[111:0]};
        end else if (s > 18'sd113) begin
            o_y = {sgn, 127'd0};
        end else begin
            o_y = {sgn, 14'd0, q + {112'd0, inc}};
        end
    end

endmodule

// ===== hw/rtl/bes_misc.sv =====
// Classify, signbit, frexp, fabs, copysign and final result selection.
module bes_misc (
    input  logic [2:0]     i_cmd,
    input  logic [127:0]   i_x,
    input  logic           i_y_sign,
    input  logic [127:0]   i_scaled,
    output bes_pkg::t_res  o_res
);

    logic [14:0]  ef;
    logic [111:0] fr;
    logic [6:0]   p;
    logic [112:0] mn;

    always_comb begin
        ef = i_x[126:112];
        fr = i_x[111:0];
        p  = bes_pkg::f_top_bit(fr);
        mn = {1'b0, fr} << (7'd112 - p);

        o_res = '0;
        case (i_cmd)
            bes_pkg::CMD_CLASSIFY: begin
                if (ef == 15'd0) begin
                    o_res.res_int = (fr != '0) ? bes_pkg::CLS_SUBNORMAL : bes_pkg::CLS_ZERO;
                end else if (ef == bes_pkg::EXP_MAX) begin
                    o_res.res_int = (fr != '0) ? bes_pkg::CLS_NAN : bes_pkg::CLS_INF;
                end else begin
                    o_res.res_int = bes_pkg::CLS_NORMAL;
                end
            end
            bes_pkg::CMD_SIGNBIT: begin
                o_res.res_int = {15'd0, i_x[127]};
            end
            bes_pkg::CMD_FREXP: begin
                // Zero, infinity and NaN come back untouched.
                if (ef == bes_pkg::EXP_MAX || (ef == 15'd0 && fr == '0)) begin
                    {o_res.res_hi, o_res.res_lo} = i_x;
                end else if (ef != 15'd0) begin
                    o_res.res_int = $signed({1'b0, ef}) - 16'sd16382;
                    {o_res.res_hi, o_res.res_lo} = {i_x[127], bes_pkg::HALF_EXP, fr};
                end else begin
                    o_res.res_int = $signed({9'd0, p}) - 16'sd16493;
                    {o_res.res_hi, o_res.res_lo} = {i_x[127], bes_pkg::HALF_EXP, mn[111:0]};
                end
            end
            bes_pkg::CMD_FABS: begin
                {o_res.res_hi, o_res.res_lo} = {1'b0, i_x[126:0]};
            end
            bes_pkg::CMD_COPYSIGN: begin
                {o_res.res_hi, o_res.res_lo} = {i_y_sign, i_x[126:0]};
            end
            bes_pkg::CMD_SCALBN: begin
                {o_res.res_hi, o_res.res_lo} = i_scaled;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

// ===== sim/binary128_exponent_sign_unit_core_tb.sv =====
module binary128_exponent_sign_unit_core_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1400;

    // A row of the directed table; when 'typed' is set, 'want' holds the answer.
    typedef struct {
        bes_pkg::t_in  item;
        bit            typed;
        bes_pkg::t_res want;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    bes_pkg::t_in  i_item;
    logic          o_done;
    bes_pkg::t_res o_res;

    bes_pkg::t_res pending_res[$];
    int            n_errors;
    int            n_results;
    int            n_cycles;
    int            n_scalbn;

    binary128_exponent_sign_unit_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Multiply a binary128 value by 2^k, k within one stage, round to nearest even.
    function automatic logic [127:0] pow2_mul(input logic [127:0] x, input int k);
        logic        sgn;
        logic [14:0] ef;
        logic [127:0] m;
        logic [127:0] q;
        int          e;
        int          b;
        int          p;
        int          s;
        sgn = x[127];
        ef  = x[126:112];
        m   = {16'b0, x[111:0]};
        if (ef == bes_pkg::EXP_MAX) begin
            if (m != '0) x[111] = 1'b1;
            return x;
        end
        if (ef == '0 && m == '0) return x;
        if (ef != '0) begin
            m[112] = 1'b1;
            e = int'(ef) - 16383 - 112;
        end else begin
            e = 1 - 16383 - 112;
        end
        p = 0;
        for (int i = 0; i < 128; i++) if (m[i]) p = i;
        m = m << (112 - p);
        e = e - (112 - p) + k;
        b = e + 112 + 16383;
        if (b >= 32767) return {sgn, bes_pkg::EXP_MAX, 112'b0};
        if (b >= 1) return {sgn, b[14:0], m[111:0]};
        // Subnormal or underflow to zero.
        s = 1 - b;
        if (s > 113) return {sgn, 127'b0};
        q = m >> s;
        if (m[s-1] && (((m & ((128'b1 << (s - 1)) - 1)) != '0) || q[0])) q = q + 1;
        q[127] = q[127] | sgn;
        return q;
    endfunction

    // Expected result of one command beat.
    function automatic bes_pkg::t_res unit_result(input bes_pkg::t_in it);
        bes_pkg::t_res r;
        logic [127:0]  x;
        logic [14:0]   ef;
        logic [111:0]  f;
        logic [127:0]  m;
        longint        n;
        int            p;
        r  = '0;
        x  = {it.x_hi, it.x_lo};
        ef = x[126:112];
        f  = x[111:0];
        case (it.cmd)
            bes_pkg::CMD_CLASSIFY: begin
                if (ef == '0) begin
                    r.res_int = (f != '0) ? bes_pkg::CLS_SUBNORMAL : bes_pkg::CLS_ZERO;
                end else if (ef == bes_pkg::EXP_MAX) begin
                    r.res_int = (f != '0) ? bes_pkg::CLS_NAN : bes_pkg::CLS_INF;
                end else begin
                    r.res_int = bes_pkg::CLS_NORMAL;
                end
            end
            bes_pkg::CMD_SIGNBIT: r.res_int = {15'b0, x[127]};
            bes_pkg::CMD_FREXP: begin
                if (ef == bes_pkg::EXP_MAX || (ef == '0 && f == '0)) begin
                    {r.res_hi, r.res_lo} = x;
                end else if (ef != '0) begin
                    r.res_int = 16'(int'(ef) - int'(bes_pkg::HALF_EXP));
                    {r.res_hi, r.res_lo} = {x[127], bes_pkg::HALF_EXP, f};
                end else begin
                    p = 0;
                    for (int i = 0; i < 112; i++) if (f[i]) p = i;
                    m = {16'b0, f} << (112 - p);
                    r.res_int = 16'(p - 16493);
                    {r.res_hi, r.res_lo} = {x[127], bes_pkg::HALF_EXP, m[111:0]};
                end
            end
            bes_pkg::CMD_FABS: {r.res_hi, r.res_lo} = {1'b0, x[126:0]};
            bes_pkg::CMD_COPYSIGN: {r.res_hi, r.res_lo} = {it.y_sign, x[126:0]};
            bes_pkg::CMD_SCALBN: begin
                n = longint'(it.scale);
                if (n > 16383) begin
                    x = pow2_mul(x, 16383);
                    n -= 16383;
                    if (n > 16383) begin
                        x = pow2_mul(x, 16383);
                        n -= 16383;
                        if (n > 16383) n = 16383;
                    end
                end else if (n < -16382) begin
                    x = pow2_mul(x, -16269);
                    n += 16269;
                    if (n < -16382) begin
                        x = pow2_mul(x, -16269);
                        n += 16269;
                        if (n < -16382) n = -16382;
                    end
                end
                {r.res_hi, r.res_lo} = pow2_mul(x, int'(n));
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic bes_pkg::t_in make_beat(input logic [2:0] c, input logic [63:0] hi,
                                               input logic [63:0] lo, input logic ys,
                                               input logic signed [31:0] sc);
        bes_pkg::t_in it;
        it.cmd    = c;
        it.x_hi   = hi;
        it.x_lo   = lo;
        it.y_sign = ys;
        it.scale  = sc;
        return it;
    endfunction

    // Random operand, biased towards the classes and exponent edges.
    function automatic logic [127:0] rand_operand();
        logic [127:0] raw;
        logic [14:0]  ef;
        raw = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0: ef = '0;
            1: begin
                ef = '0;
                raw[111:0] = raw[111:0] >> $urandom_range(0, 111);
            end
            2: ef = bes_pkg::EXP_MAX;
            3: begin
                ef = bes_pkg::EXP_MAX;
                if ($urandom_range(0, 1) == 0) raw[111:0] = '0;
            end
            4: ef = 15'($urandom_range(1, 3));
            5: ef = 15'($urandom_range(32763, 32766));
            6: ef = 15'($urandom_range(16370, 16400));
            default: ef = 15'($urandom_range(1, 32766));
        endcase
        if (ef == '0 && $urandom_range(0, 7) == 0) raw[111:0] = '0;
        raw[126:112] = ef;
        return raw;
    endfunction

    function automatic logic signed [31:0] rand_scale();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return -32'sh7fffffff - $urandom_range(0, 1);
            3: return 32'($urandom_range(16380, 16386)) * ($urandom_range(0, 1) ? 1 : -1);
            4: return -32'($urandom_range(16260, 16400));
            5: return 32'($urandom_range(32760, 32772)) * ($urandom_range(0, 1) ? 1 : -1);
            6: return -32'($urandom_range(32530, 32800));
            7: return -32'($urandom_range(16400, 16520));
            default: return 32'($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    // Drive one beat; the call starts and ends just after a rising edge.
    task automatic issue_beat(input bes_pkg::t_in it, input bit typed,
                              input bes_pkg::t_res want);
        start  <= 1'b1;
        i_item <= it;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        pending_res.push_back(typed ? want : unit_result(it));
        if (it.cmd == bes_pkg::CMD_SCALBN) n_scalbn++;
    endtask

    task automatic sender_gap();
        int len;
        case ($urandom_range(0, 9))
            0, 1, 2: len = $urandom_range(1, 3);
            3:       len = $urandom_range(8, 30);
            default: len = 0;
        endcase
        if (len > 0) begin
            start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    // Results are sampled at the falling edge, away from the driving edge.
    always @(negedge i_clk) begin
        bes_pkg::t_res want;
        if (i_rst_n && o_done) begin
            n_results++;
            if (pending_res.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, o_res);
                n_errors++;
            end else begin
                want = pending_res.pop_front();
                if (o_res.res_hi !== want.res_hi) begin
                    $display("%0t: res_hi expected %h actual %h", $time, want.res_hi,
                             o_res.res_hi);
                    n_errors++;
                end
                if (o_res.res_lo !== want.res_lo) begin
                    $display("%0t: res_lo expected %h actual %h", $time, want.res_lo,
                             o_res.res_lo);
                    n_errors++;
                end
                if (o_res.res_int !== want.res_int) begin
                    $display("%0t: res_int expected %0d actual %0d", $time, want.res_int,
                             o_res.res_int);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_row         rows[];
        bes_pkg::t_in it;
        logic [127:0] x;
        n_errors  = 0;
        n_results = 0;
        n_cycles  = 0;
        n_scalbn  = 0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_item    = '0;

        rows = '{
            '{make_beat(bes_pkg::CMD_CLASSIFY, 64'h0, 64'h0, 1'b0, 0), 1'b1,
              '{64'h0, 64'h0, bes_pkg::CLS_ZERO}},
            '{make_beat(bes_pkg::CMD_CLASSIFY, 64'h7fff000000000000, 64'h0, 1'b0, 0), 1'b1,
              '{64'h0, 64'h0, bes_pkg::CLS_INF}},
            '{make_beat(bes_pkg::CMD_CLASSIFY, 64'hffff000000000000, 64'h1, 1'b0, 0), 1'b1,
              '{64'h0, 64'h0, bes_pkg::CLS_NAN}},
            '{make_beat(bes_pkg::CMD_CLASSIFY, 64'h0, 64'h1, 1'b0, 0), 1'b1,
              '{64'h0, 64'h0, bes_pkg::CLS_SUBNORMAL}},
            '{make_beat(bes_pkg::CMD_CLASSIFY, 64'h7ffeffffffffffff, '1, 1'b1, 0), 1'b1,
              '{64'h0, 64'h0, bes_pkg::CLS_NORMAL}},
            '{make_beat(bes_pkg::CMD_SIGNBIT, 64'h8000000000000000, 64'h0, 1'b0, 0), 1'b1,
              '{64'h0, 64'h0, 16'sd1}},
            '{make_beat(bes_pkg::CMD_FABS, '1, '1, 1'b0, 0), 1'b1,
              '{64'h7fffffffffffffff, '1, 16'sd0}},
            '{make_beat(bes_pkg::CMD_COPYSIGN, 64'h3fff000000000000, 64'h5, 1'b1, 0), 1'b1,
              '{64'hbfff000000000000, 64'h5, 16'sd0}},
            '{make_beat(bes_pkg::CMD_FREXP, 64'h3fff000000000000, 64'h0, 1'b0, 0), 1'b1,
              '{64'h3ffe000000000000, 64'h0, 16'sd1}},
            '{make_beat(bes_pkg::CMD_FREXP, 64'h8000000000000000, 64'h1, 1'b0, 0), 1'b1,
              '{64'hbffe000000000000, 64'h0, -16'sd16493}},
            '{make_beat(bes_pkg::CMD_FREXP, 64'h7fff000000000001, 64'h0, 1'b0, 0), 1'b1,
              '{64'h7fff000000000001, 64'h0, 16'sd0}},
            '{make_beat(bes_pkg::CMD_FREXP, 64'h0000ffffffffffff, '1, 1'b0, 0), 1'b0, '0},
            '{make_beat(bes_pkg::CMD_FREXP, 64'h7ffe123456789abc, 64'h1, 1'b0, 0), 1'b0,
              '0},
            '{make_beat(bes_pkg::CMD_SCALBN, 64'h7fff000000000001, 64'h0, 1'b0, 3), 1'b1,
              '{64'h7fff800000000001, 64'h0, 16'sd0}},
            '{make_beat(bes_pkg::CMD_SCALBN, 64'hfffe000000000000, 64'h0, 1'b0, 1), 1'b1,
              '{64'hffff000000000000, 64'h0, 16'sd0}},
            '{make_beat(bes_pkg::CMD_SCALBN, 64'h3fff000000000000, 64'h0, 1'b0,
                        32'sh7fffffff), 1'b1,
              '{64'h7fff000000000000, 64'h0, 16'sd0}},
            '{make_beat(bes_pkg::CMD_SCALBN, 64'h3fff000000000000, 64'h0, 1'b0,
                        32'sh80000000), 1'b1,
              '{64'h0, 64'h0, 16'sd0}},
            '{make_beat(bes_pkg::CMD_SCALBN, 64'h3fff000000000000, 64'h0, 1'b0, -16494),
              1'b0, '0},
            '{make_beat(bes_pkg::CMD_SCALBN, 64'h3fffffffffffffff, '1, 1'b0, -16400),
              1'b0, '0},
            '{make_beat(bes_pkg::CMD_SCALBN, 64'h0000000000000000, 64'h3, 1'b0, 32000),
              1'b0, '0},
            '{make_beat(bes_pkg::CMD_SCALBN, 64'h8000000000000000, 64'h0, 1'b0, 5), 1'b1,
              '{64'h8000000000000000, 64'h0, 16'sd0}},
            '{make_beat(3'd6, '1, '1, 1'b1, -1), 1'b1, '{64'h0, 64'h0, 16'sd0}},
            '{make_beat(3'd7, '1, '1, 1'b1, -1), 1'b1, '{64'h0, 64'h0, 16'sd0}}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        foreach (rows[i]) issue_beat(rows[i].item, rows[i].typed, rows[i].want);
        start <= 1'b0;

        // Hold off until the pipeline has drained once.
        while (pending_res.size() != 0) @(posedge i_clk);

        // Random beats with gaps on the sender side, except for beats 200 to 399.
        for (int i = 0; i < N_RANDOM; i++) begin
            x  = rand_operand();
            it = make_beat(3'($urandom_range(0, 7)), x[127:64], x[63:0],
                           1'($urandom_range(0, 1)), rand_scale());
            if ($urandom_range(0, 9) < 4) it.cmd = bes_pkg::CMD_SCALBN;
            issue_beat(it, 1'b0, '0);
            if (i >= 200 && i < 400) continue;
            sender_gap();
        end
        start <= 1'b0;

        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d results, %0d of them scalbn, over all commands and classes.",
                 n_results, n_scalbn);
        if (n_errors == 0 && pending_res.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bes_pkg.sv
hw/rtl/bes_scale.sv
hw/rtl/bes_misc.sv
hw/rtl/binary128_exponent_sign_unit_core.sv
sim/binary128_exponent_sign_unit_core_tb.sv
